// ----- sv/pcr_extend_quote_bank_core_defines.svh -----
// assertion macros for the pcr bank core
`ifndef PCR_EXTEND_QUOTE_BANK_CORE_DEFINES_SVH
`define PCR_EXTEND_QUOTE_BANK_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the next cycle
`define PCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- sv/pcr_pkg.sv -----
// shared types, constants and sha-256 helpers for the pcr bank
package pcr_pkg;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned PCR_BYTES = 32;
	localparam logic [1:0] FUNC_EXTEND = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_QUOTE = 2'd2;

	typedef logic [255:0] hash_t;

	localparam hash_t SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one compression round on the working variables
	function automatic hash_t sha_round(input hash_t s, input logic [31:0] kw);
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		{a, b, c, d, e, f, g, h} = s;
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + kw;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		return {t1 + t2, a, b, c, d + t1, e, f, g};
	endfunction

	// next schedule word from the 16-word window, w[0] oldest in the top bits
	function automatic logic [31:0] sha_sched(input logic [511:0] w);
		logic [31:0] w0, w1, w9, w14, s0, s1;
		w0 = w[511:480];
		w1 = w[479:448];
		w9 = w[223:192];
		w14 = w[63:32];
		s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		return w0 + s0 + w9 + s1;
	endfunction

	function automatic hash_t hash_add(input hash_t x, input hash_t y);
		hash_t r;
		for (int i = 0; i < 8; i++) begin
			r[i*32 +: 32] = x[i*32 +: 32] + y[i*32 +: 32];
		end
		return r;
	endfunction
endpackage

// ----- sv/pcr_extend_quote_bank_core.sv -----
// pcr bank core: extend, read and quote over a bank of sha-256 registers
//
// request channel: valid/stall with func, reg_select and digest_w0..w3.
// result channel: valid/stall with status, value_w0..w3, logged, log_slot.
// config: extend_lock_we / extend_lock_wd write the lock bit; user writes only while idle (not enforced).
// one request is in flight at a time; stall on the request side stays high
// from acceptance until its result has been taken.
// one shared sha-256 round unit does one round per cycle, 64 rounds per block,
// followed by an add step for the chaining value; a block loads eight message
// words, and each word fetched from the bank is read from memory before it
// is shifted in. a new request is taken in idle, once the result has left.
// the bank sits in a memory of NUM_PCRS*4 words read and written one word
// a cycle; reset clears every entry through per-register valid bits, so the
// block is ready right after reset with all registers zero and log count zero.
// a stalled result holds in the output register until taken.
module pcr_extend_quote_bank_core
	import pcr_pkg::*;
#(
	parameter int unsigned NUM_PCRS = 16,
	parameter int unsigned LOG_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        extend_lock_we,
	input  logic        extend_lock_wd,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [4:0]  reg_select,
	input  logic [63:0] digest_w0,
	input  logic [63:0] digest_w1,
	input  logic [63:0] digest_w2,
	input  logic [63:0] digest_w3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [63:0] value_w0,
	output logic [63:0] value_w1,
	output logic [63:0] value_w2,
	output logic [63:0] value_w3,
	output logic        logged,
	output logic [5:0]  log_slot
);
	`include "pcr_extend_quote_bank_core_defines.svh"

	localparam int unsigned SEL_W = (NUM_PCRS > 1) ? $clog2(NUM_PCRS) : 1;
	localparam int unsigned ADDR_W = SEL_W + 2;
	localparam int unsigned DEPTH = NUM_PCRS * 4;
	localparam int unsigned CNT_W = $clog2(LOG_ENTRIES + 1);
	// message blocks of a quote, padding included
	localparam int unsigned QBLK = (NUM_PCRS * 32 + 9 + 63) / 64;
	localparam int unsigned QBLK_W = $clog2(QBLK + 1);
	localparam int unsigned QBITS = NUM_PCRS * 32 * 8;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_RDW, ST_LOAD, ST_ROUND, ST_ADD, ST_WB, ST_OUT
	} state_t;

	state_t state_q;
	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;
	logic [NUM_PCRS-1:0] written_q;
	logic lock_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] func_q;
	logic [SEL_W-1:0] sel_q;
	logic [255:0] dig_q;
	logic [ADDR_W:0] widx_q;      // words fetched into the current block or written back
	logic [QBLK_W-1:0] blk_q;     // block number of the message
	logic [511:0] w_q;            // schedule window
	logic [5:0] rnd_q;
	hash_t st_q;
	hash_t h_q;
	logic [255:0] res_q;
	logic rd_pend_q;
	logic [1:0] rd_lane_q;

	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic we;
	logic [63:0] wdata;
	logic bad_sel;
	logic rd_en;

	assign bad_sel = ({3'b0, reg_select} >= 8'(NUM_PCRS));
	assign in_stall = (state_q != ST_IDLE);

	// padding marker word right after the message
	function automatic logic [63:0] pad_word(input logic [ADDR_W+QBLK_W+1:0] pos,
		input logic [ADDR_W+QBLK_W+1:0] len_w);
		logic [63:0] r;
		r = '0;
		if (pos == len_w) r = 64'h8000_0000_0000_0000;
		return r;
	endfunction

	logic [ADDR_W+QBLK_W+1:0] msg_pos;
	logic [63:0] msg_word;
	logic [63:0] mem_word;
	logic [ADDR_W+QBLK_W+1:0] len_w;
	logic [63:0] len_bits;
	logic last_blk;
	logic [SEL_W-1:0] rd_pcr;
	logic [SEL_W-1:0] rd_pcr_q;

	assign rd_pcr = rd_pcr_q;
	assign msg_pos = ((ADDR_W+QBLK_W+2)'(blk_q) << 3) + (ADDR_W+QBLK_W+2)'(widx_q);
	assign len_w = (func_q == FUNC_QUOTE) ? (ADDR_W+QBLK_W+2)'(DEPTH) : (ADDR_W+QBLK_W+2)'(8);
	assign len_bits = (func_q == FUNC_QUOTE) ? 64'(QBITS) : 64'd512;
	assign last_blk = (func_q == FUNC_QUOTE) ? (blk_q == QBLK_W'(QBLK - 1)) :
		(blk_q == QBLK_W'(1));
	assign mem_word = written_q[rd_pcr] ? rdata_q : 64'd0;

	always_comb begin
		msg_word = pad_word(msg_pos, len_w);
		if (last_blk && widx_q == (ADDR_W+1)'(7)) msg_word = len_bits;
		if (msg_pos < len_w) begin
			if (func_q == FUNC_QUOTE || widx_q < (ADDR_W+1)'(4)) msg_word = mem_word;
			else msg_word = dig_q[(3 - widx_q[1:0]) * 64 +: 64];
		end
	end

	// memory address: quote reads word msg_pos, extend reads sel*4+widx, read reads sel*4+lane
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		if (state_q == ST_LOAD && !rd_pend_q) begin
			if (func_q == FUNC_QUOTE) begin
				rd_en = (msg_pos < len_w);
				raddr = ADDR_W'(msg_pos);
			end else begin
				rd_en = (widx_q < (ADDR_W+1)'(4)) && (blk_q == '0);
				raddr = {sel_q, widx_q[1:0]};
			end
		end else if (state_q == ST_RD) begin
			rd_en = 1'b1;
			raddr = {sel_q, rd_lane_q};
		end
		we = (state_q == ST_WB);
		waddr = {sel_q, widx_q[1:0]};
		wdata = res_q[(3 - widx_q[1:0]) * 64 +: 64];
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	logic load_need_mem;
	assign load_need_mem = rd_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			written_q <= '0;
			lock_q <= 1'b0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_lane_q <= '0;
			widx_q <= '0;
			blk_q <= '0;
			rnd_q <= '0;
			func_q <= '0;
			sel_q <= '0;
			rd_pcr_q <= '0;
			dig_q <= '0;
			w_q <= '0;
			st_q <= '0;
			h_q <= '0;
			res_q <= '0;
			status <= 1'b0;
			logged <= 1'b0;
			log_slot <= '0;
			value_w0 <= '0;
			value_w1 <= '0;
			value_w2 <= '0;
			value_w3 <= '0;
		end else begin
			if (extend_lock_we) lock_q <= extend_lock_wd;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						sel_q <= SEL_W'(reg_select);
						rd_pcr_q <= SEL_W'(reg_select);
						dig_q <= {digest_w0, digest_w1, digest_w2, digest_w3};
						status <= 1'b0;
						logged <= 1'b0;
						log_slot <= '0;
						value_w0 <= '0;
						value_w1 <= '0;
						value_w2 <= '0;
						value_w3 <= '0;
						widx_q <= '0;
						blk_q <= '0;
						rnd_q <= '0;
						rd_lane_q <= '0;
						rd_pend_q <= 1'b0;
						h_q <= SHA_IV;
						priority if (func == FUNC_EXTEND && (bad_sel || lock_q)) begin
							status <= 1'b1;
							state_q <= ST_OUT;
							out_valid <= 1'b1;
						end else if (func == FUNC_EXTEND) begin
							state_q <= ST_LOAD;
						end else if (func == FUNC_READ && bad_sel) begin
							status <= 1'b1;
							state_q <= ST_OUT;
							out_valid <= 1'b1;
						end else if (func == FUNC_READ) begin
							state_q <= ST_RD;
						end else if (func == FUNC_QUOTE) begin
							rd_pcr_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							status <= 1'b1;
							state_q <= ST_OUT;
							out_valid <= 1'b1;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					res_q[(3 - rd_lane_q) * 64 +: 64] <= written_q[sel_q] ? rdata_q : 64'd0;
					rd_lane_q <= rd_lane_q + 2'd1;
					if (rd_lane_q == 2'd3) begin
						value_w0 <= res_q[255:192];
						value_w1 <= res_q[191:128];
						value_w2 <= res_q[127:64];
						value_w3 <= written_q[sel_q] ? rdata_q : 64'd0;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_LOAD: begin
					// fetch one message word per pass; a memory word is first read, then shifted in
					if (load_need_mem) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						w_q <= {w_q[447:0], msg_word};
						if (func_q == FUNC_QUOTE && msg_pos < len_w && widx_q[1:0] == 2'd3) begin
							rd_pcr_q <= rd_pcr_q + SEL_W'(1);
						end
						if (widx_q == (ADDR_W+1)'(7)) begin
							widx_q <= '0;
							st_q <= h_q;
							rnd_q <= '0;
							state_q <= ST_ROUND;
						end else begin
							widx_q <= widx_q + (ADDR_W+1)'(1);
						end
					end
				end
				ST_ROUND: begin
					st_q <= sha_round(st_q, sha_k(rnd_q) + w_q[511:480]);
					w_q <= {w_q[479:0], sha_sched(w_q)};
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q <= hash_add(h_q, st_q);
					res_q <= hash_add(h_q, st_q);
					if (last_blk) begin
						if (func_q == FUNC_EXTEND) begin
							state_q <= ST_WB;
						end else begin
							value_w0 <= 64'(hash_add(h_q, st_q) >> 192);
							value_w1 <= 64'(hash_add(h_q, st_q) >> 128);
							value_w2 <= 64'(hash_add(h_q, st_q) >> 64);
							value_w3 <= 64'(hash_add(h_q, st_q));
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end else begin
						blk_q <= blk_q + QBLK_W'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_WB: begin
					widx_q <= widx_q + (ADDR_W+1)'(1);
					if (widx_q == (ADDR_W+1)'(3)) begin
						written_q[sel_q] <= 1'b1;
						value_w0 <= res_q[255:192];
						value_w1 <= res_q[191:128];
						value_w2 <= res_q[127:64];
						value_w3 <= res_q[63:0];
						if (cnt_q < CNT_W'(LOG_ENTRIES)) begin
							logged <= 1'b1;
							log_slot <= 6'(cnt_q);
							cnt_q <= cnt_q + CNT_W'(1);
						end
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PCR_ASSERT_IMP(a_out_only_done, out_valid, state_q == ST_OUT, "result valid outside done state")
	`PCR_ASSERT_IMP(a_rej_zero, out_valid && status, value_w0 == '0 && !logged, "rejected result not zero")
	`PCR_ASSERT_NXT(a_cnt_grow, state_q == ST_WB && widx_q == (ADDR_W+1)'(3) && cnt_q < CNT_W'(LOG_ENTRIES), logged, "extend did not log")
	`PCR_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CNT_W'(LOG_ENTRIES), "log count past limit")
endmodule
